// File: rtl/pcrr_pkg.sv
// Shared constants and types for the palette color range remap block.
package pcrr_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
	localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

	localparam int IDX_W = 8;
	localparam int CHAN_W = 8;
	localparam int COLOR_W = 24;
	localparam int LIGHT_W = 17;
	localparam int SCALE_W = 24;
	localparam int DIST_W = 18;
	localparam int SQ_W = 2 * CHAN_W;
	localparam int FRAC_W = 16;

	localparam int IN_DATA_W = 104;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [LIGHT_W-1:0] T_ONE = LIGHT_W'(65536);

	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_FLOOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_SCALE = 1'b1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic vld;
		logic [IDX_W-1:0] idx;
	} scan_tag_t;

endpackage

// File: rtl/pcrr_dist.sv
// Squared RGB distance unit shared by every palette entry of a scan.
module pcrr_dist (
	input logic clk,
	input logic arst_n,
	input logic [pcrr_pkg::COLOR_W-1:0] target,
	input logic [pcrr_pkg::COLOR_W-1:0] color,
	input pcrr_pkg::scan_tag_t tag_in,
	output pcrr_pkg::scan_tag_t tag_out,
	output logic [pcrr_pkg::DIST_W-1:0] sq_dist
);
	import pcrr_pkg::*;

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	logic [CHAN_W-1:0] dr, dg, db;
	logic [SQ_W-1:0] r_sq_s2, g_sq_s2, b_sq_s2;
	scan_tag_t tag_s2;

	assign dr = abs_diff(target[23:16], color[23:16]);
	assign dg = abs_diff(target[15:8], color[15:8]);
	assign db = abs_diff(target[7:0], color[7:0]);

	always_ff @(posedge clk) begin
		r_sq_s2 <= dr * dr;
		g_sq_s2 <= dg * dg;
		b_sq_s2 <= db * db;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_in;
		end
	end

	assign tag_out = tag_s2;
	assign sq_dist = DIST_W'(r_sq_s2) + DIST_W'(g_sq_s2) + DIST_W'(b_sq_s2);

endmodule

// File: rtl/palette_color_range_remap.sv
// Top level of the palette color range remap block: sequencer, palette memory and output.
//
// Input requests arrive on the s_axis channel. tuser carries the command: a load
// writes entry_color into palette slot entry_index in the cycle it is accepted and
// produces no result. A query normalizes its lightness with the light_floor and
// light_scale registers, interpolates a target color between low_color and
// high_color, and scans the whole palette for the nearest entry.
// A query runs these steps from acceptance until its result is registered: the
// lightness multiply, the per-channel interpolation on one multiplier, channel by
// channel, and one palette read per cycle through the palette read register and the
// registered distance unit, plus drain.
// s_axis_tready is low for the whole of a query.
// The result waits in an output register on m_axis; new requests are accepted while
// it waits. A query that finishes while the previous result is still stalled holds
// in its last cycle until m_axis_tready takes the old one.
// Reset clears the sequencer, the output valid and the registers to their defaults;
// the palette is not cleared and must be loaded before it is queried.
// Configuration writes are taken at any edge with cfg_we high, and are meant for idle.
module palette_color_range_remap (
	input logic clk,
	input logic arst_n,
	// Fields from bit 0: entry_index[7:0], entry_color[31:8], lightness[48:32],
	// force_full[49], low_color[73:50], high_color[97:74], zero fill.
	input logic [pcrr_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// Fields from bit 0: command.
	input logic s_axis_tuser,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// Fields from bit 0: best_index[7:0], best_distance[25:8], zero fill.
	output logic [pcrr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic cfg_we,
	input logic [pcrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pcrr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pcrr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NORM = 3'd1;
	localparam logic [2:0] ST_MIX = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [1:0] CH_RED = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE = 2'd2;

	logic [2:0] state_q;
	logic [1:0] mix_ch_q;
	logic [CNT_W-1:0] rd_addr_q;

	logic [LIGHT_W-1:0] light_floor_q;
	logic [SCALE_W-1:0] light_scale_q;

	logic [LIGHT_W-1:0] lightness_q;
	logic force_full_q;
	logic [COLOR_W-1:0] low_color_q, high_color_q;
	logic [LIGHT_W-1:0] t_q;
	logic [COLOR_W-1:0] target_q;

	logic [COLOR_W-1:0] palette_mem [PALETTE_ENTRIES];
	logic [COLOR_W-1:0] rd_data_s1;
	scan_tag_t tag_s1, tag_s2;
	logic [DIST_W-1:0] dist_s2;

	logic [IDX_W-1:0] best_idx_q;
	logic [DIST_W-1:0] best_dist_q;
	logic out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic in_req, load_req, query_req, out_free, scan_issue, scan_end;
	logic [IDX_W-1:0] in_index;
	logic [LIGHT_W-1:0] norm_diff;
	logic [LIGHT_W+SCALE_W-1:0] norm_prod;
	logic [LIGHT_W+SCALE_W-FRAC_W-1:0] norm_shift;
	logic [LIGHT_W-1:0] norm_t;
	logic [CHAN_W-1:0] mix_lo, mix_hi, mix_mag, mix_step, mix_out;
	logic [LIGHT_W+CHAN_W-1:0] mix_prod;

	assign in_req = s_axis_tvalid && s_axis_tready;
	assign load_req = in_req && (s_axis_tuser == CMD_LOAD);
	assign query_req = in_req && (s_axis_tuser == CMD_QUERY);
	assign in_index = s_axis_tdata[7:0];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_axis_tready;
	assign scan_issue = (state_q == ST_SCAN) && (rd_addr_q < CNT_W'(PALETTE_ENTRIES));
	assign scan_end = (state_q == ST_SCAN) && (rd_addr_q == CNT_W'(PALETTE_ENTRIES))
		&& !tag_s1.vld && !tag_s2.vld;

	// Lightness normalization: subtract the floor, scale, clamp to one; force_full gives one.
	assign norm_diff = lightness_q - light_floor_q;
	assign norm_prod = norm_diff * light_scale_q;
	assign norm_shift = norm_prod[LIGHT_W+SCALE_W-1:FRAC_W];

	always_comb begin
		if (force_full_q) begin
			norm_t = T_ONE;
		end else if (lightness_q <= light_floor_q) begin
			norm_t = '0;
		end else if (norm_shift > (LIGHT_W+SCALE_W-FRAC_W)'(T_ONE)) begin
			norm_t = T_ONE;
		end else begin
			norm_t = norm_shift[LIGHT_W-1:0];
		end
	end

	// One channel of the interpolation per cycle, truncated toward the low color.
	always_comb begin
		case (mix_ch_q)
			CH_RED: begin
				mix_lo = low_color_q[23:16];
				mix_hi = high_color_q[23:16];
			end
			CH_GREEN: begin
				mix_lo = low_color_q[15:8];
				mix_hi = high_color_q[15:8];
			end
			default: begin
				mix_lo = low_color_q[7:0];
				mix_hi = high_color_q[7:0];
			end
		endcase
	end

	assign mix_mag = (mix_hi >= mix_lo) ? mix_hi - mix_lo : mix_lo - mix_hi;
	assign mix_prod = t_q * mix_mag;
	assign mix_step = CHAN_W'(mix_prod >> FRAC_W);
	assign mix_out = (mix_hi >= mix_lo) ? mix_lo + mix_step : mix_lo - mix_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_floor_q <= '0;
			light_scale_q <= SCALE_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LIGHT_FLOOR: light_floor_q <= cfg_data[LIGHT_W-1:0];
				CFG_LIGHT_SCALE: light_scale_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mix_ch_q <= CH_RED;
			rd_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (query_req) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					mix_ch_q <= CH_RED;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					if (mix_ch_q == CH_BLUE) begin
						rd_addr_q <= '0;
						state_q <= ST_SCAN;
					end else begin
						mix_ch_q <= mix_ch_q + 2'd1;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						rd_addr_q <= rd_addr_q + CNT_W'(1);
					end
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (query_req) begin
			lightness_q <= s_axis_tdata[48:32];
			force_full_q <= s_axis_tdata[49];
			low_color_q <= s_axis_tdata[73:50];
			high_color_q <= s_axis_tdata[97:74];
		end
		if (state_q == ST_NORM) begin
			t_q <= norm_t;
		end
		if (state_q == ST_MIX) begin
			case (mix_ch_q)
				CH_RED: target_q[23:16] <= mix_out;
				CH_GREEN: target_q[15:8] <= mix_out;
				default: target_q[7:0] <= mix_out;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_req && ({1'b0, in_index} < 9'(PALETTE_ENTRIES))) begin
			palette_mem[in_index[ADDR_W-1:0]] <= s_axis_tdata[31:8];
		end
		rd_data_s1 <= palette_mem[rd_addr_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld <= scan_issue;
			tag_s1.idx <= IDX_W'(rd_addr_q[ADDR_W-1:0]);
		end
	end

	pcrr_dist u_dist (
		.clk(clk),
		.arst_n(arst_n),
		.target(target_q),
		.color(rd_data_s1),
		.tag_in(tag_s1),
		.tag_out(tag_s2),
		.sq_dist(dist_s2)
	);

	// The first entry always takes the lead; later ones only on a strictly smaller distance.
	always_ff @(posedge clk) begin
		if (tag_s2.vld && ((tag_s2.idx == '0) || (dist_s2 < best_dist_q))) begin
			best_idx_q <= tag_s2.idx;
			best_dist_q <= dist_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_data_q <= {(OUT_DATA_W-DIST_W-IDX_W)'(0), best_dist_q, best_idx_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	a_dist_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s2.vld |-> (state_q == ST_SCAN))
		else $error("distance unit active outside of a palette scan");

	a_done_after_full_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (rd_addr_q == CNT_W'(PALETTE_ENTRIES)))
		else $error("query finished before every palette entry was read");

	a_query_starts_norm: assert property (@(posedge clk) disable iff (!arst_n)
		query_req |=> (state_q == ST_NORM))
		else $error("accepted query did not start normalization");

	a_result_only_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result presented without a finished query");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the palette color range remap block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pcrr_pkg::*;

	localparam int DRAIN_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [DIST_W-1:0] distance;
	} remap_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [COLOR_W-1:0] palette_model [PALETTE_ENTRIES];
	logic [LIGHT_W-1:0] floor_model;
	logic [SCALE_W-1:0] scale_model;
	remap_result_t pending_remaps[$];
	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	palette_color_range_remap dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic [CHAN_W-1:0] blend_channel(logic [CHAN_W-1:0] lo,
			logic [CHAN_W-1:0] hi, logic [LIGHT_W-1:0] level);
		logic [31:0] step;
		if (hi >= lo) begin
			step = (32'(level) * 32'(hi - lo)) >> FRAC_W;
			return lo + step[CHAN_W-1:0];
		end
		step = (32'(level) * 32'(lo - hi)) >> FRAC_W;
		return lo - step[CHAN_W-1:0];
	endfunction

	function automatic int channel_sq(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
		int delta;
		delta = int'(a) - int'(b);
		return delta * delta;
	endfunction

	function automatic remap_result_t nearest_palette_entry(logic [LIGHT_W-1:0] light,
			logic force_one, logic [COLOR_W-1:0] lo, logic [COLOR_W-1:0] hi);
		longint unsigned level;
		logic [CHAN_W-1:0] tr, tg, tb;
		logic [COLOR_W-1:0] c;
		int best_d;
		int d;
		remap_result_t r;
		if (force_one) begin
			level = 65536;
		end else if (light <= floor_model) begin
			level = 0;
		end else begin
			level = ((64'(light) - 64'(floor_model)) * 64'(scale_model)) >> FRAC_W;
			if (level > 65536) level = 65536;
		end
		tr = blend_channel(lo[23:16], hi[23:16], level[LIGHT_W-1:0]);
		tg = blend_channel(lo[15:8], hi[15:8], level[LIGHT_W-1:0]);
		tb = blend_channel(lo[7:0], hi[7:0], level[LIGHT_W-1:0]);
		best_d = 32'h7FFF_FFFF;
		r = '0;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			c = palette_model[i];
			d = channel_sq(tr, c[23:16]) + channel_sq(tg, c[15:8]) + channel_sq(tb, c[7:0]);
			if (d < best_d) begin
				best_d = d;
				r.index = IDX_W'(i);
			end
		end
		r.distance = DIST_W'(best_d);
		return r;
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color(logic coarse);
		logic [COLOR_W-1:0] c;
		c = COLOR_W'($urandom);
		if (coarse) begin
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(3))
					0: c[8*k +: 8] = 8'h00;
					1: c[8*k +: 8] = 8'h40;
					2: c[8*k +: 8] = 8'h80;
					default: c[8*k +: 8] = 8'hFF;
				endcase
			end
		end
		return c;
	endfunction

	task automatic send_request(logic cmd, logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] ecol,
			logic [LIGHT_W-1:0] light, logic force_one, logic [COLOR_W-1:0] lo,
			logic [COLOR_W-1:0] hi);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= IN_DATA_W'({hi, lo, force_one, light, ecol, idx});
		do @(posedge clk); while (!s_axis_tready);
		if (cmd == CMD_LOAD)
			palette_model[idx] = ecol;
		else
			pending_remaps.push_back(nearest_palette_entry(light, force_one, lo, hi));
	endtask

	task automatic load_entry(logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] ecol);
		send_request(CMD_LOAD, idx, ecol, LIGHT_W'($urandom), 1'($urandom),
			COLOR_W'($urandom), COLOR_W'($urandom));
	endtask

	task automatic query_remap(logic [LIGHT_W-1:0] light, logic force_one,
			logic [COLOR_W-1:0] lo, logic [COLOR_W-1:0] hi);
		send_request(CMD_QUERY, IDX_W'($urandom), COLOR_W'($urandom), light, force_one, lo, hi);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_remaps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] which, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (which == CFG_LIGHT_FLOOR)
			floor_model = value[LIGHT_W-1:0];
		else
			scale_model = value[SCALE_W-1:0];
	endtask

	task automatic set_registers(int floor_value, int scale_value);
		wait_idle();
		write_register(CFG_LIGHT_FLOOR, CFG_DATA_W'(floor_value));
		write_register(CFG_LIGHT_SCALE, CFG_DATA_W'(scale_value));
	endtask

	task automatic test_palette_fill(logic coarse);
		for (int i = 0; i < PALETTE_ENTRIES; i++)
			load_entry(IDX_W'(i), pick_color(coarse));
	endtask

	task automatic test_directed_queries();
		load_entry(8'd0, 24'h000000);
		load_entry(8'd255, 24'hFFFFFF);
		load_entry(8'd7, 24'h123456);
		load_entry(8'd200, 24'h123456);
		load_entry(8'd128, 24'h800000);
		query_remap(17'd0, 1'b0, 24'h000000, 24'hFFFFFF);
		query_remap(17'd65536, 1'b0, 24'h000000, 24'hFFFFFF);
		query_remap(17'h1FFFF, 1'b0, 24'h000000, 24'hFFFFFF);
		query_remap(17'd0, 1'b1, 24'h000000, 24'hFFFFFF);
		query_remap(17'd1, 1'b0, 24'h000000, 24'hFFFFFF);
		query_remap(17'd32768, 1'b0, 24'hFFFFFF, 24'h000000);
		query_remap(17'd21845, 1'b0, 24'hFF00FF, 24'h00FF00);
		query_remap(17'd40000, 1'b0, 24'h123456, 24'h123456);
		query_remap(17'd65535, 1'b0, 24'hFFFFFF, 24'h000001);
	endtask

	task automatic test_register_extremes();
		set_registers(65536, 24'hFFFFFF);
		query_remap(17'd65536, 1'b0, 24'h000000, 24'hFFFFFF);
		query_remap(17'd65537, 1'b0, 24'h000000, 24'hFFFFFF);
		query_remap(17'h1FFFF, 1'b0, 24'hFFFFFF, 24'h000000);
		set_registers(0, 0);
		query_remap(17'h1FFFF, 1'b0, 24'h000000, 24'hFFFFFF);
		query_remap(17'h1FFFF, 1'b1, 24'h000000, 24'hFFFFFF);
	endtask

	task automatic test_random_traffic(int count, int idle_pct, int stall_pct, logic coarse);
		logic [LIGHT_W-1:0] light;
		logic [COLOR_W-1:0] lo;
		logic [COLOR_W-1:0] hi;
		int near;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 40) begin
				load_entry(IDX_W'($urandom), pick_color(coarse));
			end else begin
				case ($urandom_range(3))
					0: light = LIGHT_W'($urandom_range(65536));
					1: light = LIGHT_W'($urandom);
					2: begin
						near = int'(floor_model) + $urandom_range(64) - 32;
						if (near < 0) near = 0;
						light = LIGHT_W'(near);
					end
					default: begin
						case ($urandom_range(2))
							0: light = '0;
							1: light = LIGHT_W'(65536);
							default: light = '1;
						endcase
					end
				endcase
				lo = pick_color(coarse && $urandom_range(1));
				hi = ($urandom_range(7) == 0) ? lo : pick_color(coarse && $urandom_range(1));
				query_remap(light, ($urandom_range(9) == 0), lo, hi);
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		remap_result_t want;
		remap_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.index = m_axis_tdata[IDX_W-1:0];
			got.distance = m_axis_tdata[IDX_W +: DIST_W];
			if (pending_remaps.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("Unexpected result: index %0d distance %0d.",
						got.index, got.distance);
			end else begin
				want = pending_remaps.pop_front();
				if (got.index != want.index || got.distance != want.distance) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("Mismatch: expected index %0d distance %0d, got index %0d distance %0d.",
							want.index, want.distance, got.index, got.distance);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_LOAD;
		s_axis_tvalid = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LIGHT_FLOOR;
		cfg_data = '0;
		floor_model = '0;
		scale_model = SCALE_W'(65536);
		foreach (palette_model[i]) palette_model[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_register(CFG_LIGHT_FLOOR, CFG_DATA_W'(0));
		write_register(CFG_LIGHT_SCALE, CFG_DATA_W'(65536));
		test_palette_fill(1'b0);
		test_directed_queries();
		test_register_extremes();

		set_registers(0, 65536);
		test_random_traffic(190, 0, 0, 1'b0);
		set_registers(0, 24'hFFFFFF);
		test_random_traffic(190, 74, 0, 1'b0);
		set_registers(65536, 0);
		test_random_traffic(190, 0, 74, 1'b0);
		set_registers($urandom_range(65536), $urandom_range(262144));
		send_idle_pct = 21;
		recv_stall_pct = 21;
		test_palette_fill(1'b1);
		test_random_traffic(190, 21, 21, 1'b1);
		set_registers(16384, 87381);
		test_random_traffic(190, 0, 0, 1'b1);
		set_registers($urandom_range(65536), $urandom_range(24'hFFFFFF));
		test_random_traffic(190, 21, 21, 1'b0);
		wait_idle();

		fail_count += pending_remaps.size();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// File: palette_color_range_remap.f
rtl/pcrr_pkg.sv
rtl/pcrr_dist.sv
rtl/palette_color_range_remap.sv
tb/testbench.sv
